// ===== hdl/cpu8_pkg.sv =====
`timescale 1ns / 1ps

package cpu8_pkg;

    // Action codes as they arrive on the input.
    localparam logic [5:0] ACT_ADC   = 6'd0;
    localparam logic [5:0] ACT_SBC   = 6'd1;
    localparam logic [5:0] ACT_AND   = 6'd2;
    localparam logic [5:0] ACT_ORA   = 6'd3;
    localparam logic [5:0] ACT_EOR   = 6'd4;
    localparam logic [5:0] ACT_CMP   = 6'd5;
    localparam logic [5:0] ACT_CPX   = 6'd6;
    localparam logic [5:0] ACT_CPY   = 6'd7;
    localparam logic [5:0] ACT_BIT   = 6'd8;
    localparam logic [5:0] ACT_LDA   = 6'd9;
    localparam logic [5:0] ACT_LDX   = 6'd10;
    localparam logic [5:0] ACT_LDY   = 6'd11;
    localparam logic [5:0] ACT_ASL_A = 6'd12;
    localparam logic [5:0] ACT_LSR_A = 6'd13;
    localparam logic [5:0] ACT_ROL_A = 6'd14;
    localparam logic [5:0] ACT_ROR_A = 6'd15;
    localparam logic [5:0] ACT_ASL_M = 6'd16;
    localparam logic [5:0] ACT_LSR_M = 6'd17;
    localparam logic [5:0] ACT_ROL_M = 6'd18;
    localparam logic [5:0] ACT_ROR_M = 6'd19;
    localparam logic [5:0] ACT_INC   = 6'd20;
    localparam logic [5:0] ACT_DEC   = 6'd21;
    localparam logic [5:0] ACT_INX   = 6'd22;
    localparam logic [5:0] ACT_INY   = 6'd23;
    localparam logic [5:0] ACT_DEX   = 6'd24;
    localparam logic [5:0] ACT_DEY   = 6'd25;
    localparam logic [5:0] ACT_TAX   = 6'd26;
    localparam logic [5:0] ACT_TAY   = 6'd27;
    localparam logic [5:0] ACT_TXA   = 6'd28;
    localparam logic [5:0] ACT_TYA   = 6'd29;
    localparam logic [5:0] ACT_TSX   = 6'd30;
    localparam logic [5:0] ACT_TXS   = 6'd31;
    localparam logic [5:0] ACT_CLC   = 6'd32;
    localparam logic [5:0] ACT_SEC   = 6'd33;
    localparam logic [5:0] ACT_CLI   = 6'd34;
    localparam logic [5:0] ACT_SEI   = 6'd35;
    localparam logic [5:0] ACT_CLV   = 6'd36;
    localparam logic [5:0] ACT_STA   = 6'd37;
    localparam logic [5:0] ACT_STX   = 6'd38;
    localparam logic [5:0] ACT_STY   = 6'd39;
    localparam logic [5:0] ACT_BPL   = 6'd40;
    localparam logic [5:0] ACT_BMI   = 6'd41;
    localparam logic [5:0] ACT_BVC   = 6'd42;
    localparam logic [5:0] ACT_BVS   = 6'd43;
    localparam logic [5:0] ACT_BCC   = 6'd44;
    localparam logic [5:0] ACT_BCS   = 6'd45;
    localparam logic [5:0] ACT_BNE   = 6'd46;
    localparam logic [5:0] ACT_BEQ   = 6'd47;

    // Bit positions in the status byte.
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] RESET_SP    = 8'hFD;
    localparam logic [7:0] RESET_FLAGS = 8'h24;

    // Sub-operation selectors, meaning depends on the kind.
    localparam logic [1:0] LOG_AND = 2'd0;
    localparam logic [1:0] LOG_ORA = 2'd1;
    localparam logic [1:0] LOG_EOR = 2'd2;

    localparam logic [1:0] SH_ASL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ROL = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [1:0] FSEL_C = 2'd0;
    localparam logic [1:0] FSEL_I = 2'd1;
    localparam logic [1:0] FSEL_V = 2'd2;

    localparam logic [1:0] BR_N = 2'd0;
    localparam logic [1:0] BR_V = 2'd1;
    localparam logic [1:0] BR_C = 2'd2;
    localparam logic [1:0] BR_Z = 2'd3;

    typedef enum logic [3:0] {
        K_NOP,
        K_ADD,
        K_LOGIC,
        K_CMP,
        K_BIT,
        K_MOVE,
        K_SHIFT,
        K_INCDEC,
        K_FLAG,
        K_BRANCH
    } kind_t;

    typedef enum logic [2:0] {
        REG_A,
        REG_X,
        REG_Y,
        REG_S,
        REG_M,
        REG_NONE
    } reg_sel_t;

    typedef struct packed {
        logic [5:0] action;
        logic [7:0] operand;
    } in_item_t;

    typedef struct packed {
        logic [7:0] write_data;
        logic       write_valid;
        logic       branch_taken;
        logic [7:0] flags_out;
        logic [7:0] acc_out;
        logic [7:0] x_out;
        logic [7:0] y_out;
        logic [7:0] sp_out;
    } out_item_t;

    // Classified operation as it travels from the front to the back.
    // alt: SBC inverts the operand, decrement, flag value, branch on set.
    typedef struct packed {
        kind_t      kind;
        reg_sel_t   src;
        reg_sel_t   dst;
        logic [1:0] sub;
        logic       alt;
        logic [7:0] operand;
    } dec_item_t;

endpackage

// ===== hdl/cpu8_front.sv =====
`timescale 1ns / 1ps

module cpu8_front
(
    input  cpu8_pkg::in_item_t  item,
    input  logic                push,
    input  logic                q_full,
    output logic                q_write,
    output cpu8_pkg::dec_item_t q_data
);

    assign q_write = push && !q_full;

    always_comb
    begin
        q_data.kind    = cpu8_pkg::K_NOP;
        q_data.src     = cpu8_pkg::REG_NONE;
        q_data.dst     = cpu8_pkg::REG_NONE;
        q_data.sub     = item.action[1:0];
        q_data.alt     = 1'b0;
        q_data.operand = item.operand;

        unique case (item.action)
            cpu8_pkg::ACT_ADC:
            begin
                q_data.kind = cpu8_pkg::K_ADD;
            end
            cpu8_pkg::ACT_SBC:
            begin
                q_data.kind = cpu8_pkg::K_ADD;
                q_data.alt  = 1'b1;
            end
            cpu8_pkg::ACT_AND:
            begin
                q_data.kind = cpu8_pkg::K_LOGIC;
                q_data.sub  = cpu8_pkg::LOG_AND;
            end
            cpu8_pkg::ACT_ORA:
            begin
                q_data.kind = cpu8_pkg::K_LOGIC;
                q_data.sub  = cpu8_pkg::LOG_ORA;
            end
            cpu8_pkg::ACT_EOR:
            begin
                q_data.kind = cpu8_pkg::K_LOGIC;
                q_data.sub  = cpu8_pkg::LOG_EOR;
            end
            cpu8_pkg::ACT_CMP:
            begin
                q_data.kind = cpu8_pkg::K_CMP;
                q_data.src  = cpu8_pkg::REG_A;
            end
            cpu8_pkg::ACT_CPX:
            begin
                q_data.kind = cpu8_pkg::K_CMP;
                q_data.src  = cpu8_pkg::REG_X;
            end
            cpu8_pkg::ACT_CPY:
            begin
                q_data.kind = cpu8_pkg::K_CMP;
                q_data.src  = cpu8_pkg::REG_Y;
            end
            cpu8_pkg::ACT_BIT:
            begin
                q_data.kind = cpu8_pkg::K_BIT;
            end
            cpu8_pkg::ACT_LDA:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_M;
                q_data.dst  = cpu8_pkg::REG_A;
            end
            cpu8_pkg::ACT_LDX:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_M;
                q_data.dst  = cpu8_pkg::REG_X;
            end
            cpu8_pkg::ACT_LDY:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_M;
                q_data.dst  = cpu8_pkg::REG_Y;
            end
            cpu8_pkg::ACT_ASL_A, cpu8_pkg::ACT_LSR_A,
            cpu8_pkg::ACT_ROL_A, cpu8_pkg::ACT_ROR_A:
            begin
                // The low two bits of the code pick the shift.
                q_data.kind = cpu8_pkg::K_SHIFT;
                q_data.src  = cpu8_pkg::REG_A;
                q_data.dst  = cpu8_pkg::REG_A;
            end
            cpu8_pkg::ACT_ASL_M, cpu8_pkg::ACT_LSR_M,
            cpu8_pkg::ACT_ROL_M, cpu8_pkg::ACT_ROR_M:
            begin
                q_data.kind = cpu8_pkg::K_SHIFT;
                q_data.src  = cpu8_pkg::REG_M;
                q_data.dst  = cpu8_pkg::REG_M;
            end
            cpu8_pkg::ACT_INC:
            begin
                q_data.kind = cpu8_pkg::K_INCDEC;
                q_data.src  = cpu8_pkg::REG_M;
                q_data.dst  = cpu8_pkg::REG_M;
            end
            cpu8_pkg::ACT_DEC:
            begin
                q_data.kind = cpu8_pkg::K_INCDEC;
                q_data.src  = cpu8_pkg::REG_M;
                q_data.dst  = cpu8_pkg::REG_M;
                q_data.alt  = 1'b1;
            end
            cpu8_pkg::ACT_INX:
            begin
                q_data.kind = cpu8_pkg::K_INCDEC;
                q_data.src  = cpu8_pkg::REG_X;
                q_data.dst  = cpu8_pkg::REG_X;
            end
            cpu8_pkg::ACT_INY:
            begin
                q_data.kind = cpu8_pkg::K_INCDEC;
                q_data.src  = cpu8_pkg::REG_Y;
                q_data.dst  = cpu8_pkg::REG_Y;
            end
            cpu8_pkg::ACT_DEX:
            begin
                q_data.kind = cpu8_pkg::K_INCDEC;
                q_data.src  = cpu8_pkg::REG_X;
                q_data.dst  = cpu8_pkg::REG_X;
                q_data.alt  = 1'b1;
            end
            cpu8_pkg::ACT_DEY:
            begin
                q_data.kind = cpu8_pkg::K_INCDEC;
                q_data.src  = cpu8_pkg::REG_Y;
                q_data.dst  = cpu8_pkg::REG_Y;
                q_data.alt  = 1'b1;
            end
            cpu8_pkg::ACT_TAX:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_A;
                q_data.dst  = cpu8_pkg::REG_X;
            end
            cpu8_pkg::ACT_TAY:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_A;
                q_data.dst  = cpu8_pkg::REG_Y;
            end
            cpu8_pkg::ACT_TXA:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_X;
                q_data.dst  = cpu8_pkg::REG_A;
            end
            cpu8_pkg::ACT_TYA:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_Y;
                q_data.dst  = cpu8_pkg::REG_A;
            end
            cpu8_pkg::ACT_TSX:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_S;
                q_data.dst  = cpu8_pkg::REG_X;
            end
            cpu8_pkg::ACT_TXS:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_X;
                q_data.dst  = cpu8_pkg::REG_S;
            end
            cpu8_pkg::ACT_CLC:
            begin
                q_data.kind = cpu8_pkg::K_FLAG;
                q_data.sub  = cpu8_pkg::FSEL_C;
            end
            cpu8_pkg::ACT_SEC:
            begin
                q_data.kind = cpu8_pkg::K_FLAG;
                q_data.sub  = cpu8_pkg::FSEL_C;
                q_data.alt  = 1'b1;
            end
            cpu8_pkg::ACT_CLI:
            begin
                q_data.kind = cpu8_pkg::K_FLAG;
                q_data.sub  = cpu8_pkg::FSEL_I;
            end
            cpu8_pkg::ACT_SEI:
            begin
                q_data.kind = cpu8_pkg::K_FLAG;
                q_data.sub  = cpu8_pkg::FSEL_I;
                q_data.alt  = 1'b1;
            end
            cpu8_pkg::ACT_CLV:
            begin
                q_data.kind = cpu8_pkg::K_FLAG;
                q_data.sub  = cpu8_pkg::FSEL_V;
            end
            cpu8_pkg::ACT_STA:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_A;
                q_data.dst  = cpu8_pkg::REG_M;
            end
            cpu8_pkg::ACT_STX:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_X;
                q_data.dst  = cpu8_pkg::REG_M;
            end
            cpu8_pkg::ACT_STY:
            begin
                q_data.kind = cpu8_pkg::K_MOVE;
                q_data.src  = cpu8_pkg::REG_Y;
                q_data.dst  = cpu8_pkg::REG_M;
            end
            cpu8_pkg::ACT_BPL, cpu8_pkg::ACT_BMI, cpu8_pkg::ACT_BVC, cpu8_pkg::ACT_BVS,
            cpu8_pkg::ACT_BCC, cpu8_pkg::ACT_BCS, cpu8_pkg::ACT_BNE, cpu8_pkg::ACT_BEQ:
            begin
                // Bits 2:1 pick the flag, bit 0 means branch when it is set.
                q_data.kind = cpu8_pkg::K_BRANCH;
                q_data.sub  = item.action[2:1];
                q_data.alt  = item.action[0];
            end
            default:
            begin
                q_data.kind = cpu8_pkg::K_NOP;
            end
        endcase
    end

endmodule

// ===== hdl/cpu8_queue.sv =====
`timescale 1ns / 1ps

module cpu8_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  cpu8_pkg::dec_item_t wr_data,
    input  logic                rd_en,
    output cpu8_pkg::dec_item_t rd_data,
    output logic                q_full,
    output logic                q_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpu8_pkg::dec_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !wr_en)
        else $error("write into a full queue");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !rd_en)
        else $error("read from an empty queue");

endmodule

// ===== hdl/cpu8_back.sv =====
`timescale 1ns / 1ps

module cpu8_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  cpu8_pkg::dec_item_t dec,
    input  logic                q_empty,
    output logic                q_read,
    input  logic                pop,
    output logic                empty,
    output cpu8_pkg::out_item_t result
);

    logic [7:0] a_reg;
    logic [7:0] a_next;
    logic [7:0] x_reg;
    logic [7:0] x_next;
    logic [7:0] y_reg;
    logic [7:0] y_next;
    logic [7:0] s_reg;
    logic [7:0] s_next;
    logic [7:0] p_reg;
    logic [7:0] p_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    cpu8_pkg::out_item_t result_reg;
    cpu8_pkg::out_item_t result_next;

    logic       take;
    logic [7:0] src_val;
    logic [7:0] addend;
    logic [8:0] sum;
    logic [8:0] diff;
    logic [7:0] res;
    logic       upd_nz;
    logic       wr_dst;
    logic       wvalid;
    logic [7:0] wdata;
    logic       taken;

    // A new item runs whenever the output register is free or being emptied.
    assign take   = !q_empty && (!out_valid_reg || pop);
    assign q_read = take;
    assign empty  = !out_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        unique case (dec.src)
            cpu8_pkg::REG_A: src_val = a_reg;
            cpu8_pkg::REG_X: src_val = x_reg;
            cpu8_pkg::REG_Y: src_val = y_reg;
            cpu8_pkg::REG_S: src_val = s_reg;
            cpu8_pkg::REG_M: src_val = dec.operand;
            default:         src_val = dec.operand;
        endcase
    end

    // SBC is an add of the inverted operand with the same carry in.
    assign addend = dec.alt ? ~dec.operand : dec.operand;
    assign sum    = {1'b0, a_reg} + {1'b0, addend} + {8'd0, p_reg[cpu8_pkg::FLAG_C]};
    assign diff   = {1'b0, src_val} - {1'b0, dec.operand};

    always_comb
    begin
        a_next = a_reg;
        x_next = x_reg;
        y_next = y_reg;
        s_next = s_reg;
        p_next = p_reg;
        res    = src_val;
        upd_nz = 1'b0;
        wr_dst = 1'b0;
        wvalid = 1'b0;
        wdata  = 8'd0;
        taken  = 1'b0;

        unique case (dec.kind)
            cpu8_pkg::K_ADD:
            begin
                res = sum[7:0];
                p_next[cpu8_pkg::FLAG_C] = sum[8];
                p_next[cpu8_pkg::FLAG_V] = ~(a_reg[7] ^ addend[7]) & (a_reg[7] ^ sum[7]);
                a_next = sum[7:0];
                upd_nz = 1'b1;
            end
            cpu8_pkg::K_LOGIC:
            begin
                unique case (dec.sub)
                    cpu8_pkg::LOG_AND: res = a_reg & dec.operand;
                    cpu8_pkg::LOG_ORA: res = a_reg | dec.operand;
                    default:           res = a_reg ^ dec.operand;
                endcase
                a_next = res;
                upd_nz = 1'b1;
            end
            cpu8_pkg::K_CMP:
            begin
                res = diff[7:0];
                p_next[cpu8_pkg::FLAG_C] = ~diff[8];
                upd_nz = 1'b1;
            end
            cpu8_pkg::K_BIT:
            begin
                p_next[cpu8_pkg::FLAG_N] = dec.operand[7];
                p_next[cpu8_pkg::FLAG_V] = dec.operand[6];
                p_next[cpu8_pkg::FLAG_Z] = ((a_reg & dec.operand) == 8'd0);
            end
            cpu8_pkg::K_MOVE:
            begin
                res    = src_val;
                wr_dst = 1'b1;
                // Stores and the move into the stack pointer leave N and Z alone.
                upd_nz = (dec.dst != cpu8_pkg::REG_S) && (dec.dst != cpu8_pkg::REG_M);
            end
            cpu8_pkg::K_SHIFT:
            begin
                unique case (dec.sub)
                    cpu8_pkg::SH_ASL:
                    begin
                        res = {src_val[6:0], 1'b0};
                        p_next[cpu8_pkg::FLAG_C] = src_val[7];
                    end
                    cpu8_pkg::SH_LSR:
                    begin
                        res = {1'b0, src_val[7:1]};
                        p_next[cpu8_pkg::FLAG_C] = src_val[0];
                    end
                    cpu8_pkg::SH_ROL:
                    begin
                        res = {src_val[6:0], p_reg[cpu8_pkg::FLAG_C]};
                        p_next[cpu8_pkg::FLAG_C] = src_val[7];
                    end
                    default:
                    begin
                        res = {p_reg[cpu8_pkg::FLAG_C], src_val[7:1]};
                        p_next[cpu8_pkg::FLAG_C] = src_val[0];
                    end
                endcase
                wr_dst = 1'b1;
                upd_nz = 1'b1;
            end
            cpu8_pkg::K_INCDEC:
            begin
                res    = dec.alt ? src_val - 8'd1 : src_val + 8'd1;
                wr_dst = 1'b1;
                upd_nz = 1'b1;
            end
            cpu8_pkg::K_FLAG:
            begin
                unique case (dec.sub)
                    cpu8_pkg::FSEL_C: p_next[cpu8_pkg::FLAG_C] = dec.alt;
                    cpu8_pkg::FSEL_I: p_next[cpu8_pkg::FLAG_I] = dec.alt;
                    default:          p_next[cpu8_pkg::FLAG_V] = dec.alt;
                endcase
            end
            cpu8_pkg::K_BRANCH:
            begin
                unique case (dec.sub)
                    cpu8_pkg::BR_N: taken = (p_reg[cpu8_pkg::FLAG_N] == dec.alt);
                    cpu8_pkg::BR_V: taken = (p_reg[cpu8_pkg::FLAG_V] == dec.alt);
                    cpu8_pkg::BR_C: taken = (p_reg[cpu8_pkg::FLAG_C] == dec.alt);
                    default:        taken = (p_reg[cpu8_pkg::FLAG_Z] == dec.alt);
                endcase
            end
            default:
            begin
                res = src_val;
            end
        endcase

        if (wr_dst)
        begin
            unique case (dec.dst)
                cpu8_pkg::REG_A: a_next = res;
                cpu8_pkg::REG_X: x_next = res;
                cpu8_pkg::REG_Y: y_next = res;
                cpu8_pkg::REG_S: s_next = res;
                cpu8_pkg::REG_M:
                begin
                    wvalid = 1'b1;
                    wdata  = res;
                end
                default:
                begin
                    wvalid = 1'b0;
                end
            endcase
        end

        if (upd_nz)
        begin
            p_next[cpu8_pkg::FLAG_Z] = (res == 8'd0);
            p_next[cpu8_pkg::FLAG_N] = res[7];
        end
    end

    always_comb
    begin
        result_next.write_data   = wdata;
        result_next.write_valid  = wvalid;
        result_next.branch_taken = taken;
        result_next.flags_out    = p_next;
        result_next.acc_out      = a_next;
        result_next.x_out        = x_next;
        result_next.y_out        = y_next;
        result_next.sp_out       = s_next;
        out_valid_next           = take || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= 8'd0;
            x_reg         <= 8'd0;
            y_reg         <= 8'd0;
            s_reg         <= cpu8_pkg::RESET_SP;
            p_reg         <= cpu8_pkg::RESET_FLAGS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                a_reg <= a_next;
                x_reg <= x_next;
                y_reg <= y_next;
                s_reg <= s_next;
                p_reg <= p_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!q_empty && (!out_valid_reg || pop)))
        else $error("item executed without room for its result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> out_valid_reg)
        else $error("waiting result dropped without a pop");

    a_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg[cpu8_pkg::FLAG_U] && !p_reg[cpu8_pkg::FLAG_B])
        else $error("unused or break bit of the status byte changed");

    a_regs_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> (p_reg == $past(p_reg) && a_reg == $past(a_reg)))
        else $error("register state changed with no item executed");

endmodule

// ===== hdl/cpu_8bit_execute_unit.sv =====
`timescale 1ns / 1ps

// Execute unit for decoded 6502-style operations. Each item carries an action code and an
// operand byte already fetched; the unit holds A, X, Y, SP and the status byte and returns one
// result item per input item: the write-back byte and its valid mark, the branch decision and
// all registers after the operation. Throughput is one item per clock cycle while results
// are popped as offered; an accepted item sits in the QUEUE_DEPTH-entry queue between the
// decoder and the execute stage, is executed into the output register once the register is
// free or being popped and is offered from there. Results are taken in order through empty/pop.
module cpu_8bit_execute_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  cpu8_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output cpu8_pkg::out_item_t result
);

    logic                q_write;
    logic                q_read;
    logic                q_full;
    logic                q_empty;
    cpu8_pkg::dec_item_t q_wr_data;
    cpu8_pkg::dec_item_t q_rd_data;

    assign full = q_full;

    cpu8_front u_front
    (
        .item    (item),
        .push    (push),
        .q_full  (q_full),
        .q_write (q_write),
        .q_data  (q_wr_data)
    );

    cpu8_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_write),
        .wr_data (q_wr_data),
        .rd_en   (q_read),
        .rd_data (q_rd_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    cpu8_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .dec     (q_rd_data),
        .q_empty (q_empty),
        .q_read  (q_read),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
